// ===== rtl/core/cmps_pkg.sv =====
// Shared types and constants of the Catmull-Rom path sampler.
package cmps_pkg;

   localparam int COORD_W = 32;
   localparam int SPS_W = 5;
   localparam logic [SPS_W-1:0] SPS_RESET = 5'd20;
   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] ADDR_SPS = 3'd0;
   localparam int ACC_W = 88;
   localparam int QUO_W = 17;
   localparam int DIV_STEPS = 17;

   // Controller states
   typedef enum logic [9:0] {
      ST_IDLE = 10'b0000000001,
      ST_DIV  = 10'b0000000010,
      ST_PLAN = 10'b0000000100,
      ST_SEG  = 10'b0000001000,
      ST_SAMP = 10'b0000010000,
      ST_MUL  = 10'b0000100000,
      ST_ADD  = 10'b0001000000,
      ST_EMIT = 10'b0010000000,
      ST_END  = 10'b0100000000,
      ST_DONE = 10'b1000000000
   } state_type;

   // Segment selection
   localparam logic SEG_INNER = 1'b0;
   localparam logic SEG_FINAL = 1'b1;

   // Horner term selection
   localparam logic [1:0] TERM_B  = 2'd0;
   localparam logic [1:0] TERM_A  = 2'd1;
   localparam logic [1:0] TERM_P1 = 2'd2;

   typedef struct packed {
      logic       capture;
      logic       div_init;
      logic       div_step;
      logic       div_bit;
      logic       seg_load;
      logic       seg_sel;
      logic [1:0] count;
      logic       samp_init;
      logic       mul_step;
      logic [1:0] digit;
      logic       add_term;
      logic [1:0] stage;
      logic       emit_sample;
      logic       emit_end;
      logic       eor;
      logic       win_update;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic s_last;
   } status_type;

endpackage

// ===== rtl/core/cmps_axis.sv =====
// One coordinate axis: window, coefficients and Horner evaluation.
module cmps_axis (
   input  logic                                 clock,
   input  cmps_pkg::cmd_type                    cmd,
   input  logic signed [cmps_pkg::COORD_W-1:0]  coord_in,
   input  logic [3:0]                           t_digit,
   output logic signed [cmps_pkg::COORD_W-1:0]  cur_out,
   output logic signed [cmps_pkg::COORD_W-1:0]  sample_out
);

   localparam int AW = cmps_pkg::ACC_W;

   logic signed [31:0] w0_ff, w1_ff, w2_ff, cur_ff;
   logic signed [32:0] a_ff, a_in;
   logic signed [35:0] b_ff, b_in;
   logic signed [34:0] c_ff, c_in;
   logic signed [31:0] p1_ff;
   logic signed [AW-1:0] h_ff, p_ff;
   logic signed [31:0] p0, p1, p2, p3;
   logic signed [35:0] e0, e1, e2, e3;
   logic signed [AW-1:0] prod, term;
   logic hi_ok;

   // Control points of the segment being loaded
   always_comb begin
      if (cmd.seg_sel == cmps_pkg::SEG_INNER) begin
         p0 = (cmd.count == 2'd3) ? w0_ff : w1_ff;
         p1 = w1_ff;
         p2 = w2_ff;
         p3 = cur_ff;
      end else begin
         p0 = (cmd.count >= 2'd2) ? w1_ff : w2_ff;
         p1 = w2_ff;
         p2 = cur_ff;
         p3 = cur_ff;
      end
      e0 = 36'(p0);
      e1 = 36'(p1);
      e2 = 36'(p2);
      e3 = 36'(p3);
      a_in = 33'(p2) - 33'(p0);
      b_in = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
      c_in = 35'(e1 + (e1 <<< 1) - e2 - (e2 <<< 1) + e3 - e0);
   end

   // One four-bit digit of the multiplication by t, and the Horner terms
   always_comb begin
      prod = AW'(h_ff * $signed({1'b0, t_digit}));
      case (cmd.stage)
         cmps_pkg::TERM_B:  term = AW'(b_ff) <<< 16;
         cmps_pkg::TERM_A:  term = AW'(a_ff) <<< 32;
         cmps_pkg::TERM_P1: term = AW'(p1_ff) <<< 49;
         default:           term = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cur_ff <= coord_in;
      end
      if (cmd.win_update) begin
         w0_ff <= w1_ff;
         w1_ff <= w2_ff;
         w2_ff <= cur_ff;
      end
      if (cmd.seg_load) begin
         a_ff <= a_in;
         b_ff <= b_in;
         c_ff <= c_in;
         p1_ff <= p1;
      end
      if (cmd.samp_init) begin
         h_ff <= AW'(c_ff);
         p_ff <= '0;
      end else if (cmd.mul_step) begin
         p_ff <= (p_ff <<< 4) + prod;
      end else if (cmd.add_term) begin
         h_ff <= p_ff + term;
         p_ff <= '0;
      end
   end

   // Floor by the arithmetic shift, then saturate to 32 bits
   assign hi_ok = (h_ff[AW-1:80] == {(AW-80){h_ff[80]}});
   assign sample_out = hi_ok ? h_ff[80:49] : (h_ff[AW-1] ? 32'sh80000000 : 32'sh7FFFFFFF);
   assign cur_out = cur_ff;

endmodule

// ===== rtl/core/cmps_datapath.sv =====
// Datapath: step divider, sample position generator, two axes and result register.
module cmps_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  cmps_pkg::cmd_type             cmd,
   input  logic [cmps_pkg::SPS_W-1:0]    sps,
   input  logic [63:0]                   req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [63:0]                   rsp_tdata,
   output logic                          rsp_tlast,
   output cmps_pkg::status_type          status
);

   logic [cmps_pkg::QUO_W-1:0] dq_ff, dq_in, q_ff, q_in;
   logic [4:0] dr_ff, dr_in, r_ff, r_in, s_ff;
   logic [5:0] dsh, rsum;
   logic [3:0] digit;
   logic [15:0] t_val;
   logic signed [31:0] cx, cy, sx, sy;
   logic valid_ff, valid_in;
   logic [63:0] data_ff;
   logic last_ff;

   // Restoring division of 2^16 by the sample count, one bit a step
   always_comb begin
      dsh = {dr_ff, cmd.div_bit};
      if (dsh >= {1'b0, sps}) begin
         dr_in = 5'(dsh - {1'b0, sps});
         dq_in = {dq_ff[cmps_pkg::QUO_W-2:0], 1'b1};
      end else begin
         dr_in = dsh[4:0];
         dq_in = {dq_ff[cmps_pkg::QUO_W-2:0], 1'b0};
      end
   end

   // Next sample position: quotient and remainder advance by the step
   always_comb begin
      rsum = {1'b0, r_ff} + {1'b0, dr_ff};
      if (rsum >= {1'b0, sps}) begin
         r_in = 5'(rsum - {1'b0, sps});
         q_in = q_ff + dq_ff + 17'd1;
      end else begin
         r_in = rsum[4:0];
         q_in = q_ff + dq_ff;
      end
   end

   assign t_val = q_ff[15:0];
   assign digit = t_val[4*(3-cmd.digit) +: 4];

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         dq_ff <= '0;
         dr_ff <= '0;
      end else if (cmd.div_step) begin
         dq_ff <= dq_in;
         dr_ff <= dr_in;
      end
      if (cmd.seg_load) begin
         q_ff <= '0;
         r_ff <= '0;
         s_ff <= '0;
      end else if (cmd.emit_sample) begin
         q_ff <= q_in;
         r_ff <= r_in;
         s_ff <= s_ff + 5'd1;
      end
   end

   cmps_axis u_axis_x (
      .clock      (clock),
      .cmd        (cmd),
      .coord_in   (req_tdata[31:0]),
      .t_digit    (digit),
      .cur_out    (cx),
      .sample_out (sx)
   );

   cmps_axis u_axis_y (
      .clock      (clock),
      .cmd        (cmd),
      .coord_in   (req_tdata[63:32]),
      .t_digit    (digit),
      .cur_out    (cy),
      .sample_out (sy)
   );

   // Result register: holds one item until the consumer takes it
   always_comb begin
      valid_in = valid_ff;
      if (cmd.emit_sample || cmd.emit_end) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (cmd.emit_sample) begin
         data_ff <= {sy, sx};
         last_ff <= cmd.eor;
      end else if (cmd.emit_end) begin
         data_ff <= {cy, cx};
         last_ff <= 1'b1;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = data_ff;
   assign rsp_tlast = last_ff;
   assign status.out_free = !valid_ff || rsp_tready;
   assign status.s_last = (s_ff == 5'(sps - 5'd1));

endmodule

// ===== rtl/core/cmps_ctrl.sv =====
// Controller: sequences division, segments, Horner steps and result hand-off.
module cmps_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic                        req_tlast,
   input  logic                        sps_zero,
   input  cmps_pkg::status_type        status,
   output cmps_pkg::cmd_type           cmd
);

   cmps_pkg::state_type state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [1:0] dig_ff, dig_in, stage_ff, stage_in, c_ff, c_in, seen_ff, seen_in;
   logic last_ff, last_in, sel_ff, sel_in, seg1_ff, seg1_in, seg2_ff, seg2_in;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      dig_in = dig_ff;
      stage_in = stage_ff;
      c_in = c_ff;
      seen_in = seen_ff;
      last_in = last_ff;
      sel_in = sel_ff;
      seg1_in = seg1_ff;
      seg2_in = seg2_ff;
      cmd = '0;
      cmd.seg_sel = sel_ff;
      cmd.count = c_ff;
      cmd.digit = dig_ff;
      cmd.stage = stage_ff;
      cmd.div_bit = (cnt_ff == 5'd0);
      req_tready = 1'b0;
      case (state_ff)
         cmps_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               cmd.div_init = 1'b1;
               c_in = seen_ff;
               last_in = req_tlast;
               seg1_in = (seen_ff >= 2'd2) && !sps_zero;
               seg2_in = req_tlast && (seen_ff >= 2'd1) && !sps_zero;
               cnt_in = '0;
               state_in = cmps_pkg::ST_DIV;
            end
         end
         cmps_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(cmps_pkg::DIV_STEPS - 1)) begin
               state_in = cmps_pkg::ST_PLAN;
            end
         end
         cmps_pkg::ST_PLAN: begin
            if (seg1_ff) begin
               sel_in = cmps_pkg::SEG_INNER;
               state_in = cmps_pkg::ST_SEG;
            end else if (seg2_ff) begin
               sel_in = cmps_pkg::SEG_FINAL;
               state_in = cmps_pkg::ST_SEG;
            end else if (last_ff) begin
               state_in = cmps_pkg::ST_END;
            end else begin
               state_in = cmps_pkg::ST_DONE;
            end
         end
         cmps_pkg::ST_SEG: begin
            cmd.seg_load = 1'b1;
            state_in = cmps_pkg::ST_SAMP;
         end
         cmps_pkg::ST_SAMP: begin
            cmd.samp_init = 1'b1;
            dig_in = '0;
            stage_in = cmps_pkg::TERM_B;
            state_in = cmps_pkg::ST_MUL;
         end
         cmps_pkg::ST_MUL: begin
            cmd.mul_step = 1'b1;
            dig_in = dig_ff + 2'd1;
            if (dig_ff == 2'd3) begin
               state_in = cmps_pkg::ST_ADD;
            end
         end
         cmps_pkg::ST_ADD: begin
            cmd.add_term = 1'b1;
            dig_in = '0;
            stage_in = stage_ff + 2'd1;
            state_in = (stage_ff == cmps_pkg::TERM_P1) ? cmps_pkg::ST_EMIT : cmps_pkg::ST_MUL;
         end
         cmps_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit_sample = 1'b1;
               cmd.eor = (sel_ff == cmps_pkg::SEG_INNER) && !last_ff && status.s_last;
               if (!status.s_last) begin
                  state_in = cmps_pkg::ST_SAMP;
               end else if (sel_ff == cmps_pkg::SEG_INNER && last_ff) begin
                  sel_in = cmps_pkg::SEG_FINAL;
                  state_in = cmps_pkg::ST_SEG;
               end else if (last_ff) begin
                  state_in = cmps_pkg::ST_END;
               end else begin
                  state_in = cmps_pkg::ST_DONE;
               end
            end
         end
         cmps_pkg::ST_END: begin
            if (status.out_free) begin
               cmd.emit_end = 1'b1;
               state_in = cmps_pkg::ST_DONE;
            end
         end
         cmps_pkg::ST_DONE: begin
            if (last_ff) begin
               seen_in = '0;
            end else begin
               cmd.win_update = 1'b1;
               seen_in = (c_ff == 2'd3) ? 2'd3 : c_ff + 2'd1;
            end
            state_in = cmps_pkg::ST_IDLE;
         end
         default: begin
            state_in = cmps_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cmps_pkg::ST_IDLE;
         seen_ff <= '0;
      end else begin
         state_ff <= state_in;
         seen_ff <= seen_in;
      end
      cnt_ff <= cnt_in;
      dig_ff <= dig_in;
      stage_ff <= stage_in;
      c_ff <= c_in;
      last_ff <= last_in;
      sel_ff <= sel_in;
      seg1_ff <= seg1_in;
      seg2_ff <= seg2_in;
   end

endmodule

// ===== rtl/core/catmull_rom_path_sampler.sv =====
// Top level of the uniform Catmull-Rom path sampler.
//
//   Channel  Direction  Content
//   req_     in         tdata: point_x [31:0], point_y [63:32]; tlast: last_point
//   rsp_     out        tdata: sample_x [31:0], sample_y [63:32]; tlast: end_of_run
//   csr_     in/out     APB register holding the segment sample count at byte address 0
//
// One item at a time. An accepted item is taken in the idle state, then passes the step
// division, a planning state and a closing state; each segment adds a set-up state and,
// per sample, three Horner steps of four 4-bit digit multiplies each, and a last point
// adds an end-point state.
// Reset is synchronous; the result register stalls the sequencer when it is full and not being taken.
module catmull_rom_path_sampler (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [63:0]                           req_tdata,   // point_x, point_y
   input  logic                                  req_tlast,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [63:0]                           rsp_tdata,   // sample_x, sample_y
   output logic                                  rsp_tlast,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [cmps_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);

   logic [cmps_pkg::SPS_W-1:0] sps_ff;
   cmps_pkg::cmd_type cmd;
   cmps_pkg::status_type status;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         sps_ff <= cmps_pkg::SPS_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == cmps_pkg::ADDR_SPS) begin
         sps_ff <= csr_pwdata[cmps_pkg::SPS_W-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == cmps_pkg::ADDR_SPS) ? {27'd0, sps_ff} : '0;

   cmps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .sps_zero   (sps_ff == '0),
      .status     (status),
      .cmd        (cmd)
   );

   cmps_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sps           (sps_ff),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .status        (status)
   );

endmodule

// ===== rtl/core/cmps_checker.sv =====
// Port-level checks of the path sampler and their binding.
module cmps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        csr_pready
);

   // A result that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("result dropped");

   // A stalled result keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // The block works on one item at a time.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready) else $error("item taken while busy");

   // Nothing is offered straight after reset.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid) else $error("result after reset");

   // The register port never waits.
   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready) else $error("register port stalled");

endmodule

bind catmull_rom_path_sampler cmps_checker u_cmps_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_pready (csr_pready)
);
